@@ hw/rtl/arx_pkg.sv @@
// arx_pkg: shared types and fixed constants of the arx model iir filter
// no dependencies; used by the interfaces, the cfg register bank, the mac and the top level
package arx_pkg;

  // coefficient format, q2.14
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 14;
  localparam logic signed [COEF_W-1:0] B0_RESET = 16'sd16384;

  // configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int DELAY_W    = 4;

  // per-tap control that travels alongside the history read
  typedef struct packed {
    logic vld;
    logic sub;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

@@ hw/rtl/arx_ifs.sv @@
// arx_ifs: valid/ready channel interfaces for samples in, samples out and register writes
// depends on arx_pkg for the configuration field widths
interface arx_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface arx_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface arx_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [arx_pkg::CFG_IDX_W-1:0]   index;
  logic [arx_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/arx_model_iir_filter.sv @@
// arx_model_iir_filter: direct form i iir (arx model) built around two history rams
// depends on arx_pkg, arx_ifs, arx_ram, arx_cfg_regs and arx_mac
//
// usage
//   in_chan   : one signed sample per request (valid/ready, taken when both high)
//   out_chan  : one rounded, saturated output sample per input request
//   cfg_chan  : register writes, index 0..NUM_B_TAPS-1 b taps, then the a taps,
//               then the input delay; always ready, write only while idle
// timing
//   an item runs one tap per cycle through the shared multiply-accumulate,
//   then through the pipeline stages (ram read, product, accumulate) and
//   a final step to round and store; out_chan.valid rises with the store.
//   in_chan.ready is high while no item is in flight; a held result in the
//   output register does not block the next request.
// reset
//   histories read as zero until written (valid bit per entry), b tap 0 = 1.0,
//   other coefficients and the delay zero. if the receiver stalls, the next
//   result waits in the round stage until the output register is free.
module arx_model_iir_filter #(
  parameter int NUM_B_TAPS  = 4,
  parameter int NUM_A_TAPS  = 3,
  parameter int MAX_DELAY   = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  arx_in_if.sink     in_chan,
  arx_out_if.source  out_chan,
  arx_cfg_if.sink    cfg_chan
);

  localparam int NT       = NUM_B_TAPS + NUM_A_TAPS;
  localparam int TW       = $clog2(NT);
  localparam int IN_DEPTH = NUM_B_TAPS + MAX_DELAY;
  localparam int IN_AW    = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int KW       = IN_AW + 1;
  localparam int OUT_AW   = (NUM_A_TAPS > 1) ? $clog2(NUM_A_TAPS) : 1;
  localparam int OW       = OUT_AW + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]                        state_r, state_nxt;
  logic [TW-1:0]                     tap_r, tap_nxt;
  logic [IN_AW-1:0]                  wp_r, wp_inc;
  logic [OUT_AW-1:0]                 op_r, op_inc;
  logic [IN_DEPTH-1:0]               ivld_r;
  logic [NUM_A_TAPS-1:0]             ovld_r;
  arx_pkg::mac_ctl_t                 st1_r;
  logic                              ent_vld1_r;
  logic signed [arx_pkg::COEF_W-1:0] coef1_r;
  logic                              out_valid_r;
  logic signed [SAMPLE_BITS-1:0]     out_data_r;

  logic                              in_acc;
  logic                              issue;
  logic                              is_b;
  logic                              last_tap;
  logic                              fin_fire;
  logic [KW-1:0]                     delay_eff;
  logic [KW-1:0]                     k_back;
  logic [KW-1:0]                     idiff;
  logic [TW-1:0]                     a_idx;
  logic [OW-1:0]                     odiff;
  logic [IN_AW-1:0]                  in_raddr;
  logic [OUT_AW-1:0]                 out_raddr;
  logic [SAMPLE_BITS-1:0]            in_rdata;
  logic [SAMPLE_BITS-1:0]            out_rdata;
  logic signed [arx_pkg::COEF_W-1:0] coef_sel;
  logic signed [SAMPLE_BITS-1:0]     mac_sample;
  logic                              mac_done;
  logic signed [SAMPLE_BITS-1:0]     mac_y;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign issue         = (state_r == S_ISSUE);
  assign is_b          = tap_r < TW'(NUM_B_TAPS);
  assign last_tap      = tap_r == TW'(NT - 1);
  assign fin_fire      = (state_r == S_FIN) & (~out_valid_r | out_chan.ready);

  // circular buffer pointers, newest entry at the pointer
  assign wp_inc = (wp_r == IN_AW'(IN_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign op_inc = (op_r == OUT_AW'(NUM_A_TAPS - 1)) ? '0 : op_r + 1'b1;

  // entry k back from newest, wrapped
  assign k_back   = delay_eff + KW'(tap_r);
  assign idiff    = {1'b0, wp_r} - k_back;
  assign in_raddr = idiff[KW-1] ? IN_AW'(idiff + KW'(IN_DEPTH)) : idiff[IN_AW-1:0];

  assign a_idx     = tap_r - TW'(NUM_B_TAPS);
  assign odiff     = {1'b0, op_r} - OW'(a_idx);
  assign out_raddr = odiff[OW-1] ? OUT_AW'(odiff + OW'(NUM_A_TAPS)) : odiff[OUT_AW-1:0];

  arx_cfg_regs #(
    .NUM_B_TAPS (NUM_B_TAPS),
    .NUM_A_TAPS (NUM_A_TAPS),
    .MAX_DELAY  (MAX_DELAY)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_chan  (cfg_chan),
    .tap_sel   (tap_r),
    .coef      (coef_sel),
    .delay_eff (delay_eff)
  );

  arx_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (IN_DEPTH)
  ) u_in_hist (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_inc),
    .wdata (in_chan.sample_in),
    .re    (issue & is_b),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  arx_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (NUM_A_TAPS)
  ) u_out_hist (
    .clk   (clk),
    .we    (fin_fire),
    .waddr (op_inc),
    .wdata (mac_y),
    .re    (issue & ~is_b),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_ISSUE;
          tap_nxt   = '0;
        end
      end
      S_ISSUE: begin
        tap_nxt = tap_r + 1'b1;
        if (last_tap) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= '0;
      wp_r        <= '0;
      op_r        <= '0;
      ivld_r      <= '0;
      ovld_r      <= '0;
      st1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      st1_r   <= '{vld: issue, sub: ~is_b, first: (tap_r == '0), last: last_tap};
      if (in_acc) begin
        wp_r           <= wp_inc;
        ivld_r[wp_inc] <= 1'b1;
      end
      if (fin_fire) begin
        op_r           <= op_inc;
        ovld_r[op_inc] <= 1'b1;
        out_valid_r    <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload side of the read stage and the output register
  always_ff @(posedge clk) begin
    coef1_r    <= coef_sel;
    ent_vld1_r <= is_b ? ivld_r[in_raddr] : ovld_r[out_raddr];
    if (fin_fire) begin
      out_data_r <= mac_y;
    end
  end

  // entries never written read as zero
  assign mac_sample = !ent_vld1_r ? '0 :
                      (st1_r.sub ? $signed(out_rdata) : $signed(in_rdata));

  arx_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NUM_TAPS    (NT)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (st1_r),
    .coef   (coef1_r),
    .sample (mac_sample),
    .done   (mac_done),
    .result (mac_y)
  );

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r;

  // no tap may still be in the pipeline when a new request is taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> (!st1_r.vld && !mac_done))
    else $error("mac pipeline busy while accepting a request");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_ISSUE && tap_r == '0))
    else $error("tap sequence did not start after request");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_chan.ready) |=>
      (state_r == S_FIN && $stable(op_r)))
    else $error("result stored while output register full");

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == S_WAIT))
    else $error("accumulator finished outside the wait state");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) < 32'(IN_DEPTH))
    else $error("input history pointer out of range");

endmodule

@@ hw/rtl/arx_ram.sv @@
// arx_ram: generic single-write, single-read synchronous ram with registered read data
// no dependencies
module arx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/arx_cfg_regs.sv @@
// arx_cfg_regs: coefficient and input delay registers written through the cfg channel
// depends on arx_pkg and arx_cfg_if; b taps sit at 0..NUM_B_TAPS-1, a taps follow
module arx_cfg_regs #(
  parameter int NUM_B_TAPS = 4,
  parameter int NUM_A_TAPS = 3,
  parameter int MAX_DELAY  = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  arx_cfg_if.sink                                  cfg_chan,
  input  logic [$clog2(NUM_B_TAPS+NUM_A_TAPS)-1:0] tap_sel,
  output logic signed [arx_pkg::COEF_W-1:0]        coef,
  output logic [((NUM_B_TAPS+MAX_DELAY > 1) ? $clog2(NUM_B_TAPS+MAX_DELAY) : 1):0] delay_eff
);

  localparam int NT       = NUM_B_TAPS + NUM_A_TAPS;
  localparam int IN_DEPTH = NUM_B_TAPS + MAX_DELAY;
  localparam int KW       = ((IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1) + 1;
  localparam int TW       = $clog2(NT);
  localparam logic [arx_pkg::CFG_IDX_W-1:0] REG_DELAY = arx_pkg::CFG_IDX_W'(NT);

  logic signed [arx_pkg::COEF_W-1:0] coef_r [NT];
  logic [arx_pkg::DELAY_W-1:0]       delay_r;
  logic                              wr;

  assign cfg_chan.ready = 1'b1;
  assign wr = cfg_chan.valid & cfg_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NT; i++) begin
        coef_r[i] <= (i == 0) ? arx_pkg::B0_RESET : '0;
      end
      delay_r <= '0;
    end else if (wr) begin
      if (cfg_chan.index < REG_DELAY) begin
        coef_r[cfg_chan.index[TW-1:0]] <= $signed(cfg_chan.data[arx_pkg::COEF_W-1:0]);
      end else if (cfg_chan.index == REG_DELAY) begin
        delay_r <= cfg_chan.data[arx_pkg::DELAY_W-1:0];
      end
    end
  end

  assign coef = coef_r[tap_sel];

  // delays above MAX_DELAY act as the longest delay, MAX_DELAY
  assign delay_eff = (32'(delay_r) > 32'(MAX_DELAY)) ? KW'(MAX_DELAY) : KW'(delay_r);

endmodule

@@ hw/rtl/arx_mac.sv @@
// arx_mac: shared multiply-accumulate with product register, then round and saturate
// depends on arx_pkg for mac_ctl_t and the coefficient format
module arx_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int NUM_TAPS    = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  arx_pkg::mac_ctl_t                   ctl,
  input  logic signed [arx_pkg::COEF_W-1:0]   coef,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                done,
  output logic signed [SAMPLE_BITS-1:0]       result
);

  localparam int PW    = SAMPLE_BITS + arx_pkg::COEF_W;
  localparam int ACC_W = PW + $clog2(NUM_TAPS) + 1;
  localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W+1)'(1 << (arx_pkg::COEF_FRAC - 1));
  localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W:0] SAT_LO   = -SAT_HI - (ACC_W+1)'(1);

  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    prod_r;
  arx_pkg::mac_ctl_t       ctl2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W:0]   rnd;
  logic signed [ACC_W:0]   quo;
  logic                    done_r;

  assign prod = coef * sample;

  always_ff @(posedge clk) begin
    prod_r <= prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl2_r <= ctl;
      done_r <= ctl2_r.vld & ctl2_r.last;
    end
  end

  assign acc_base = ctl2_r.first ? '0 : acc_r;
  assign prod_ext = ACC_W'(prod_r);

  // feedback taps are subtracted
  always_ff @(posedge clk) begin
    if (ctl2_r.vld) begin
      acc_r <= ctl2_r.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
    end
  end

  // round half up, then clamp to the sample range
  assign rnd = (ACC_W+1)'(acc_r) + RND_BIAS;
  assign quo = rnd >>> arx_pkg::COEF_FRAC;

  always_comb begin
    if (quo > SAT_HI) begin
      result = SAT_HI[SAMPLE_BITS-1:0];
    end else if (quo < SAT_LO) begin
      result = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = quo[SAMPLE_BITS-1:0];
    end
  end

  assign done = done_r;

endmodule
